// ===== rtl/lpc_pkg.sv =====
// ============================================================================
// lpc_pkg - shared types and constants for the line position centroid core
// Holds field widths, calibration reset values and controller/datapath links.
// ============================================================================
package lpc_pkg;

    localparam int NUM_SENSORS = 4;
    localparam int RD_W        = 10;
    localparam int LB_W        = 5;
    localparam int POS_W       = 16;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int LOST_W      = 3;

    localparam int OUT_MIN     = 5;
    localparam int LOST_LIMIT  = 5;

    // weight lane divider: |(x-lo)*95| < 2^17, |hi-lo| < 2^10
    localparam int W_QW        = 17;
    localparam int W_DW        = 10;
    // final divider: quotient below 2^15 once saturation is ruled out
    localparam int F_QW        = 15;
    localparam int F_DW        = 19;
    localparam int CNT_W       = 5;

    localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7FFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 16'sh8000;

    typedef logic [NUM_SENSORS-1:0][RD_W-1:0] cal_arr_t;

    localparam cal_arr_t CAL_LOW_RST  = {10'd25, 10'd23, 10'd25, 10'd24};
    localparam cal_arr_t CAL_HIGH_RST = {10'd414, 10'd139, 10'd364, 10'd173};

    typedef struct packed {
        cal_arr_t        reading;
        logic [LB_W-1:0] line_bits;
    } in_item_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic wstep;
        logic wfix;
        logic sum;
        logic fchk;
        logic fstep;
        logic fix;
    } lpc_cmd_t;

    typedef struct packed {
        logic fdiv_skip;
    } lpc_status_t;

endpackage

// ===== rtl/lpc_if.sv =====
// ============================================================================
// lpc_if - valid/ready channels of the line position centroid core
// Input channel carries sensor readings, output channel the position result.
// ============================================================================
interface lpc_in_if
    import lpc_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [RD_W-1:0] reading_0;
    logic [RD_W-1:0] reading_1;
    logic [RD_W-1:0] reading_2;
    logic [RD_W-1:0] reading_3;
    logic [LB_W-1:0] line_bits;

    modport source (output valid, reading_0, reading_1, reading_2, reading_3,
                    line_bits, input ready);
    modport sink   (input valid, reading_0, reading_1, reading_2, reading_3,
                    line_bits, output ready);
endinterface

interface lpc_out_if
    import lpc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] position_q8;
    logic                    position_valid;
    logic                    line_lost;

    modport source (output valid, position_q8, position_valid, line_lost,
                    input ready);
    modport sink   (input valid, position_q8, position_valid, line_lost,
                    output ready);
endinterface

// ===== rtl/lpc_div.sv =====
// ============================================================================
// lpc_div - unsigned restoring divider, one quotient bit per step
// Loaded with a partial remainder and the low dividend bits; QW steps.
// ============================================================================
module lpc_div #(
    parameter int QW = 17,
    parameter int DW = 10
) (
    input  logic          clk,
    input  logic          load,
    input  logic          step,
    input  logic [DW-1:0] rem_init,
    input  logic [QW-1:0] dvd_low,
    input  logic [DW-1:0] dvs,
    output logic [QW-1:0] quo
);

    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[QW-1]};
        diff     = shifted - {1'b0, dvs_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (load)
        begin
            rem_next = rem_init;
            quo_next = dvd_low;
        end
        else if (step)
        begin
            if (!diff[DW])
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (load)
        begin
            dvs_reg <= dvs;
        end
    end

    assign quo = quo_reg;

endmodule

// ===== rtl/lpc_datapath.sv =====
// ============================================================================
// lpc_datapath - weight mapping, centroid sums, final division, lost counter
// Four divider lanes form the weights; one divider forms the position.
// ============================================================================
module lpc_datapath
    import lpc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lpc_cmd_t                cmd,
    input  in_item_t                item,
    input  cal_arr_t                cal_low,
    input  cal_arr_t                cal_high,
    output lpc_status_t             status,
    output logic signed [POS_W-1:0] position_q8,
    output logic                    position_valid,
    output logic                    line_lost
);

    logic signed [RD_W:0]   dx_reg [NUM_SENSORS];
    logic signed [RD_W:0]   sp_reg [NUM_SENSORS];
    logic                   neg_reg [NUM_SENSORS];
    logic                   zero_reg [NUM_SENSORS];
    logic signed [W_QW:0]   w_reg [NUM_SENSORS];
    logic signed [19:0]     d_reg;
    logic signed [24:0]     n2_reg;
    logic                   val_reg;
    logic                   sat_reg;
    logic                   nneg_reg;
    logic [LOST_W-1:0]      lost_count_reg, lost_count_next;
    logic                   lost_pend_reg, lost_pend_next;
    logic signed [POS_W-1:0] pos_reg;
    logic                   pos_valid_reg;
    logic                   line_lost_reg;

    logic [W_QW-1:0]        num_mag [NUM_SENSORS];
    logic [W_DW-1:0]        sp_mag [NUM_SENSORS];
    logic                   neg_next [NUM_SENSORS];
    logic [W_QW-1:0]        wq [NUM_SENSORS];
    logic [F_QW-1:0]        fq;

    logic signed [19:0]     d_next;
    logic signed [24:0]     n2_next;
    logic [23:0]            n_abs;
    logic [30:0]            nmag;
    logic                   dpos;
    logic                   sat;
    logic signed [POS_W-1:0] pos_next;

    // per-lane numerator (x-lo)*95 and span magnitude
    always_comb
    begin
        logic signed [W_QW:0] dxe;
        logic signed [W_QW:0] prod;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            dxe         = (W_QW+1)'(dx_reg[i]);
            prod        = (dxe <<< 6) + (dxe <<< 5) - dxe;
            num_mag[i]  = prod[W_QW] ? W_QW'(-prod) : prod[W_QW-1:0];
            sp_mag[i]   = sp_reg[i][RD_W] ? W_DW'(-sp_reg[i]) : sp_reg[i][RD_W-1:0];
            neg_next[i] = prod[W_QW] ^ sp_reg[i][RD_W];
        end
    end

    for (genvar g = 0; g < NUM_SENSORS; g++)
    begin : g_lane
        lpc_div #(
            .QW (W_QW),
            .DW (W_DW)
        ) u_wdiv (
            .clk      (clk),
            .load     (cmd.prep),
            .step     (cmd.wstep),
            .rem_init ('0),
            .dvd_low  (num_mag[g]),
            .dvs      (sp_mag[g]),
            .quo      (wq[g])
        );
    end

    // centroid sums: offsets in half mm are 45, 15, -15, -45
    always_comb
    begin
        logic signed [24:0] a;
        logic signed [24:0] b;
        d_next  = 20'(w_reg[0]) + 20'(w_reg[1]) + 20'(w_reg[2]) + 20'(w_reg[3]);
        a       = 25'(w_reg[0]) - 25'(w_reg[3]);
        b       = 25'(w_reg[1]) - 25'(w_reg[2]);
        n2_next = (a <<< 5) + (a <<< 3) + (a <<< 2) + a + (b <<< 4) - b;
    end

    assign n_abs = n2_reg[24] ? 24'(-n2_reg) : n2_reg[23:0];
    assign nmag  = {n_abs, 7'b0};
    assign dpos  = !d_reg[19] && (d_reg != '0);
    assign sat   = {3'b0, nmag} >= {d_reg[F_DW-1:0], 15'b0};

    assign status.fdiv_skip = !dpos || sat;

    lpc_div #(
        .QW (F_QW),
        .DW (F_DW)
    ) u_fdiv (
        .clk      (clk),
        .load     (cmd.fchk),
        .step     (cmd.fstep),
        .rem_init ({3'b0, nmag[30:F_QW]}),
        .dvd_low  (nmag[F_QW-1:0]),
        .dvs      (d_reg[F_DW-1:0]),
        .quo      (fq)
    );

    always_comb
    begin
        if (!val_reg)
        begin
            pos_next = '0;
        end
        else if (sat_reg)
        begin
            pos_next = nneg_reg ? POS_MIN : POS_MAX;
        end
        else
        begin
            pos_next = nneg_reg ? -$signed({1'b0, fq}) : $signed({1'b0, fq});
        end
    end

    // consecutive no-line counter
    always_comb
    begin
        logic [LOST_W-1:0] inc;
        inc             = lost_count_reg + LOST_W'(1);
        lost_count_next = lost_count_reg;
        lost_pend_next  = lost_pend_reg;
        if (cmd.capture)
        begin
            lost_pend_next = 1'b0;
            if (item.line_bits != '0)
            begin
                lost_count_next = '0;
            end
            else if (inc > LOST_W'(LOST_LIMIT))
            begin
                lost_count_next = '0;
                lost_pend_next  = 1'b1;
            end
            else
            begin
                lost_count_next = inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lost_count_reg <= '0;
        end
        else
        begin
            lost_count_reg <= lost_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lost_pend_reg <= lost_pend_next;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            if (cmd.capture)
            begin
                dx_reg[i] <= $signed({1'b0, item.reading[i]}) - $signed({1'b0, cal_low[i]});
                sp_reg[i] <= $signed({1'b0, cal_high[i]}) - $signed({1'b0, cal_low[i]});
            end
            if (cmd.prep)
            begin
                neg_reg[i]  <= neg_next[i];
                zero_reg[i] <= (sp_reg[i] == '0);
            end
            if (cmd.wfix)
            begin
                if (zero_reg[i])
                begin
                    w_reg[i] <= (W_QW+1)'(OUT_MIN);
                end
                else if (neg_reg[i])
                begin
                    w_reg[i] <= -$signed({1'b0, wq[i]}) + (W_QW+1)'(OUT_MIN);
                end
                else
                begin
                    w_reg[i] <= $signed({1'b0, wq[i]}) + (W_QW+1)'(OUT_MIN);
                end
            end
        end
        if (cmd.sum)
        begin
            d_reg  <= d_next;
            n2_reg <= n2_next;
        end
        if (cmd.fchk)
        begin
            val_reg  <= dpos;
            sat_reg  <= sat;
            nneg_reg <= n2_reg[24];
        end
        if (cmd.fix)
        begin
            pos_reg       <= pos_next;
            pos_valid_reg <= val_reg;
            line_lost_reg <= lost_pend_reg;
        end
    end

    assign position_q8    = pos_reg;
    assign position_valid = pos_valid_reg;
    assign line_lost      = line_lost_reg;

endmodule

// ===== rtl/lpc_ctrl.sv =====
// ============================================================================
// lpc_ctrl - sequencer for the line position centroid core
// Steps one transaction through mapping, summing and division.
// ============================================================================
module lpc_ctrl
    import lpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  lpc_status_t status,
    output lpc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_WDIV,
        S_WFIX,
        S_SUM,
        S_FCHK,
        S_FDIV,
        S_FIX
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = S_WDIV;
            end
            S_WDIV:
            begin
                cmd.wstep = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(W_QW - 1))
                begin
                    state_next = S_WFIX;
                end
            end
            S_WFIX:
            begin
                cmd.wfix   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                cmd.fchk   = 1'b1;
                cnt_next   = '0;
                state_next = status.fdiv_skip ? S_FIX : S_FDIV;
            end
            S_FDIV:
            begin
                cmd.fstep = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(F_QW - 1))
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.fix        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/line_position_centroid_core.sv =====
// ============================================================================
// line_position_centroid_core - weighted centroid line position from four
// calibrated reflectance sensors, with a consecutive no-line detector.
//
//   channel   dir  handshake            payload
//   in_ch     in   valid/ready          reading_0..3, line_bits
//   out_ch    out  valid/ready          position_q8, position_valid, line_lost
//   apb       in   psel/penable/pready  paddr, pwdata, prdata (cal_low/high)
//
// A transaction runs through the four weight divider lanes and then the final
// divider before the next one is accepted.
// With a non-positive weight sum or a saturated position the final divider
// is bypassed.
// The result sits in an output register; a new transaction is accepted while
// it waits, and the sequencer stalls only before overwriting it.
// Reset restores the calibration registers and clears the no-line count.
// ============================================================================
module line_position_centroid_core
    import lpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    lpc_in_if.sink            in_ch,
    lpc_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cal_arr_t    cal_low_reg;
    cal_arr_t    cal_high_reg;
    logic [2:0]  reg_idx;
    logic        cfg_wr;
    lpc_cmd_t    cmd;
    lpc_status_t status;
    in_item_t    item;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // index bit 2 selects the high calibration bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_low_reg  <= CAL_LOW_RST;
            cal_high_reg <= CAL_HIGH_RST;
        end
        else if (cfg_wr)
        begin
            if (reg_idx[2])
            begin
                cal_high_reg[reg_idx[1:0]] <= pwdata[RD_W-1:0];
            end
            else
            begin
                cal_low_reg[reg_idx[1:0]] <= pwdata[RD_W-1:0];
            end
        end
    end

    assign prdata = {{(DATA_W-RD_W){1'b0}},
                     reg_idx[2] ? cal_high_reg[reg_idx[1:0]] : cal_low_reg[reg_idx[1:0]]};

    assign item.reading   = {in_ch.reading_3, in_ch.reading_2,
                             in_ch.reading_1, in_ch.reading_0};
    assign item.line_bits = in_ch.line_bits;

    lpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lpc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .item           (item),
        .cal_low        (cal_low_reg),
        .cal_high       (cal_high_reg),
        .status         (status),
        .position_q8    (out_ch.position_q8),
        .position_valid (out_ch.position_valid),
        .line_lost      (out_ch.line_lost)
    );

endmodule

// ===== tb/line_position_centroid_core_tb.sv =====
// ============================================================================
// line_position_centroid_core_tb - self-checking bench for the centroid core
// Drives sensor transactions through the input channel, predicts each
// position result from the calibration registers and the no-line run, and
// compares every output transaction field by field. Calibration changes
// between phases, and idle rates shift on both channels.
// ============================================================================
module line_position_centroid_core_tb
    import lpc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_HALF         = 6;
    localparam int     RESET_CYCLES     = 10;
    localparam int     SETTLE_CYCLES    = 40;
    localparam int     NUM_PHASES       = 6;
    localparam int     RANDOM_PER_PHASE = 235;
    localparam int     CAL_LOW_BASE     = 0;
    localparam int     CAL_HIGH_BASE    = NUM_SENSORS;
    localparam int     RD_MAX           = (1 << RD_W) - 1;
    localparam longint WEIGHT_SPAN      = 95;
    localparam longint POS_SCALE        = 128;
    localparam longint SENSOR_OFFSET [NUM_SENSORS] = '{45, 15, -15, -45};

    typedef struct packed {
        logic signed [POS_W-1:0] position_q8;
        logic                    position_valid;
        logic                    line_lost;
    } position_result_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    lpc_in_if  in_ch ();
    lpc_out_if out_ch ();

    line_position_centroid_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [RD_W-1:0]   cal_low_m  [NUM_SENSORS];
    logic [RD_W-1:0]   cal_high_m [NUM_SENSORS];
    logic [LOST_W-1:0] no_line_run;

    in_item_t         sensor_items [$];
    position_result_t expected_positions [$];

    logic in_taken;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_left;
    int   mismatch_count;

    always
    begin
        clk = 1'b0;
        #(CLK_HALF);
        clk = 1'b1;
        #(CLK_HALF);
    end

    function automatic position_result_t predict_position(in_item_t item);
        position_result_t r;
        longint           num2;
        longint           den;
        longint           x;
        longint           lo;
        longint           hi;
        longint           w;
        longint           q;
        int               s;
        num2 = 0;
        den  = 0;
        for (s = 0; s < NUM_SENSORS; s++)
        begin
            x  = longint'(item.reading[s]);
            lo = longint'(cal_low_m[s]);
            hi = longint'(cal_high_m[s]);
            if (hi == lo)
                w = longint'(OUT_MIN);
            else
                w = (x - lo) * WEIGHT_SPAN / (hi - lo) + longint'(OUT_MIN);
            num2 += w * SENSOR_OFFSET[s];
            den  += w;
        end
        r.position_valid = (den > 0);
        r.position_q8    = '0;
        if (den > 0)
        begin
            q = num2 * POS_SCALE / den;
            if (q > longint'(POS_MAX))
                q = longint'(POS_MAX);
            else if (q < longint'(POS_MIN))
                q = longint'(POS_MIN);
            r.position_q8 = q[POS_W-1:0];
        end
        if (item.line_bits == '0)
            no_line_run = no_line_run + 1'b1;
        else
            no_line_run = '0;
        r.line_lost = (no_line_run > LOST_W'(LOST_LIMIT));
        if (r.line_lost)
            no_line_run = '0;
        return r;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       s;
        int       a;
        int       b;
        for (s = 0; s < NUM_SENSORS; s++)
        begin
            case ($urandom_range(3))
                0: it.reading[s] = RD_W'($urandom_range(RD_MAX));
                1:
                begin
                    a = (cal_low_m[s] < cal_high_m[s]) ? int'(cal_low_m[s])
                                                       : int'(cal_high_m[s]);
                    b = (cal_low_m[s] < cal_high_m[s]) ? int'(cal_high_m[s])
                                                       : int'(cal_low_m[s]);
                    a = (a < 16) ? 0 : a - 16;
                    b = (b > RD_MAX - 16) ? RD_MAX : b + 16;
                    it.reading[s] = RD_W'($urandom_range(b, a));
                end
                2: it.reading[s] = $urandom_range(1) ? RD_W'(RD_MAX) : '0;
                default: it.reading[s] = $urandom_range(1) ? cal_low_m[s] : cal_high_m[s];
            endcase
        end
        // runs of no-line transactions reach the lost detector
        if (quiet_left > 0)
        begin
            it.line_bits = '0;
            quiet_left--;
        end
        else if ($urandom_range(9) == 0)
        begin
            it.line_bits = '0;
            quiet_left   = $urandom_range(8, 4);
        end
        else if ($urandom_range(2) == 0)
            it.line_bits = '0;
        else
            it.line_bits = LB_W'($urandom_range((1 << LB_W) - 1, 1));
        return it;
    endfunction

    task automatic push_item(int r0, int r1, int r2, int r3, int lb);
        in_item_t it;
        it.reading[0] = RD_W'(r0);
        it.reading[1] = RD_W'(r1);
        it.reading[2] = RD_W'(r2);
        it.reading[3] = RD_W'(r3);
        it.line_bits  = LB_W'(lb);
        sensor_items.push_back(it);
    endtask

    task automatic cal_write(int idx, int val);
        logic [DATA_W-1:0] wdata;
        wdata           = $urandom;
        wdata[RD_W-1:0] = RD_W'(val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx < CAL_HIGH_BASE)
            cal_low_m[idx - CAL_LOW_BASE] = wdata[RD_W-1:0];
        else
            cal_high_m[idx - CAL_HIGH_BASE] = wdata[RD_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sensor_items.size() != 0 || in_ch.valid || expected_positions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // driver and receiver
    always @(negedge clk)
    begin : driver
        in_item_t next_item;
        if (rst_n !== 1'b1)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_taken)
        begin
            if (sensor_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_item = sensor_items.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.reading_0 <= next_item.reading[0];
                in_ch.reading_1 <= next_item.reading[1];
                in_ch.reading_2 <= next_item.reading[2];
                in_ch.reading_3 <= next_item.reading[3];
                in_ch.line_bits <= next_item.line_bits;
            end
            else
                in_ch.valid <= 1'b0;
        end
        out_ch.ready <= (rst_n === 1'b1) && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor and checker
    always @(posedge clk)
    begin : monitor
        in_item_t         item;
        position_result_t exp;
        if (rst_n !== 1'b1)
        begin
            in_taken       <= 1'b0;
            no_line_run    = '0;
            mismatch_count = 0;
        end
        else
        begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_positions.size() == 0)
                begin
                    $display("%0t: unexpected transaction, position_q8 %0d", $time,
                             out_ch.position_q8);
                    mismatch_count++;
                end
                else
                begin
                    exp = expected_positions.pop_front();
                    if (out_ch.position_q8 !== exp.position_q8)
                    begin
                        $display("%0t: position_q8 expected %0d actual %0d", $time,
                                 exp.position_q8, out_ch.position_q8);
                        mismatch_count++;
                    end
                    if (out_ch.position_valid !== exp.position_valid)
                    begin
                        $display("%0t: position_valid expected %0b actual %0b", $time,
                                 exp.position_valid, out_ch.position_valid);
                        mismatch_count++;
                    end
                    if (out_ch.line_lost !== exp.line_lost)
                    begin
                        $display("%0t: line_lost expected %0b actual %0b", $time,
                                 exp.line_lost, out_ch.line_lost);
                        mismatch_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                item.reading[0] = in_ch.reading_0;
                item.reading[1] = in_ch.reading_1;
                item.reading[2] = in_ch.reading_2;
                item.reading[3] = in_ch.reading_3;
                item.line_bits  = in_ch.line_bits;
                expected_positions.push_back(predict_position(item));
            end
        end
    end

    initial
    begin
        int phase;
        int s;
        int v;
        int n;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        send_idle_pct   = 16;
        recv_idle_pct   = 53;
        quiet_left      = 0;
        for (s = 0; s < NUM_SENSORS; s++)
        begin
            cal_low_m[s]  = CAL_LOW_RST[s];
            cal_high_m[s] = CAL_HIGH_RST[s];
        end
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase != 0)
                wait_idle();
            if (phase < 2)
            begin
                send_idle_pct = 16;
                recv_idle_pct = 53;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 53;
                recv_idle_pct = 16;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                1:
                    for (s = 0; s < NUM_SENSORS; s++)
                    begin
                        cal_write(CAL_LOW_BASE + s, 0);
                        cal_write(CAL_HIGH_BASE + s, RD_MAX);
                    end
                2:
                begin
                    // zero spans and inverted spans
                    cal_write(CAL_LOW_BASE + 0, 512);
                    cal_write(CAL_HIGH_BASE + 0, 512);
                    cal_write(CAL_LOW_BASE + 1, 1);
                    cal_write(CAL_HIGH_BASE + 1, 1);
                    cal_write(CAL_LOW_BASE + 2, RD_MAX - 1);
                    cal_write(CAL_HIGH_BASE + 2, 1);
                    cal_write(CAL_LOW_BASE + 3, 700);
                    cal_write(CAL_HIGH_BASE + 3, 300);
                end
                3:
                    for (s = 0; s < NUM_SENSORS; s++)
                    begin
                        v = $urandom_range(RD_MAX - 1);
                        cal_write(CAL_LOW_BASE + s, v);
                        cal_write(CAL_HIGH_BASE + s, v + 1);
                    end
                4:
                    for (s = 0; s < NUM_SENSORS; s++)
                    begin
                        cal_write(CAL_LOW_BASE + s, $urandom_range(RD_MAX - 1));
                        cal_write(CAL_HIGH_BASE + s, $urandom_range(RD_MAX, 1));
                    end
                5:
                    for (s = 0; s < NUM_SENSORS; s++)
                    begin
                        v = $urandom_range(200);
                        cal_write(CAL_LOW_BASE + s, v);
                        cal_write(CAL_HIGH_BASE + s, $urandom_range(RD_MAX, v + 100));
                    end
                default: ;
            endcase
            if (phase == 0)
            begin
                push_item(24, 25, 23, 25, 5'b00001);
                push_item(173, 364, 139, 414, 5'b00010);
                push_item(173, 25, 23, 25, 5'b00100);
                push_item(24, 364, 23, 25, 5'b01000);
                push_item(24, 25, 139, 25, 5'b10000);
                push_item(24, 25, 23, 414, 5'b11111);
                push_item(0, 0, 0, 0, 5'b00000);
                push_item(RD_MAX, RD_MAX, RD_MAX, RD_MAX, 5'b00000);
                push_item(43, 0, 0, 0, 5'b00000);
                push_item(0, 0, 0, 111, 5'b10000);
                push_item(42, 0, 0, 0, 5'b00000);
                for (n = 0; n < 6; n++)
                    push_item($urandom_range(RD_MAX), $urandom_range(RD_MAX),
                              $urandom_range(RD_MAX), $urandom_range(RD_MAX), 5'b00000);
                push_item(RD_MAX, 0, RD_MAX, 0, 5'b10101);
                push_item(0, RD_MAX, 0, RD_MAX, 5'b01010);
            end
            for (n = 0; n < RANDOM_PER_PHASE; n++)
                sensor_items.push_back(random_item());
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lpc_pkg.sv
rtl/lpc_if.sv
rtl/lpc_div.sv
rtl/lpc_datapath.sv
rtl/lpc_ctrl.sv
rtl/line_position_centroid_core.sv
tb/line_position_centroid_core_tb.sv
